### hdl/rarm_pkg.sv
package rarm_pkg;

    localparam int OPERAND_BITS = 15;
    localparam int NUM_OUT_BITS = 31;
    localparam int DEN_OUT_BITS = 30;
    // raw sum needs one bit above the product width
    localparam int RAW_BITS = 2 * OPERAND_BITS + 1;
    localparam int ALU_BITS = RAW_BITS + 1;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_EQ  = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [OPERAND_BITS-1:0] a_numerator;
        logic [OPERAND_BITS-1:0] a_denominator;
        logic [OPERAND_BITS-1:0] b_numerator;
        logic [OPERAND_BITS-1:0] b_denominator;
    } t_in_beat;

    typedef struct packed {
        logic [NUM_OUT_BITS-1:0] result_numerator;
        logic [DEN_OUT_BITS-1:0] result_denominator;
        logic                    fractions_equal;
    } t_out_beat;

endpackage

### hdl/rarm_alu.sv
module rarm_alu (
    input  logic [rarm_pkg::ALU_BITS-1:0] i_a,
    input  logic [rarm_pkg::ALU_BITS-1:0] i_b,
    output logic [rarm_pkg::ALU_BITS-1:0] o_diff,
    output logic                          o_ge
);

    logic [rarm_pkg::ALU_BITS:0] w_sub;

    // borrow out of the subtract gives the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[rarm_pkg::ALU_BITS-1:0];
    assign o_ge   = ~w_sub[rarm_pkg::ALU_BITS];

endmodule

### hdl/rational_add_multiply_reduce.sv
// Rational add / multiply with gcd reduction, and exact field compare.
// Input channel: i_in_valid with i_in_data, o_in_stall back to the sender.
// A beat is taken when valid is high and stall is low. Output channel:
// o_out_valid with o_out_data, i_out_stall from the receiver.
// One beat is worked at a time; o_in_stall stays high while it is busy.
// Compare and the unused code go from idle straight to the done state. Add
// and multiply run the products through one multiplier in states S_M0 to
// S_M3, then a binary gcd on one shared subtract/compare unit, one shift,
// subtract or swap per cycle, then two restoring divisions of the raw
// 31-bit values by the gcd on the same unit.
// When the raw numerator or denominator is zero the gcd and divisions are
// skipped. The result sits in an output register, so a new beat is taken
// while the previous result still waits on a stalled receiver; the block
// finishes the next beat only once that register frees up.
// Reset (synchronous, active low) returns to idle and drops o_out_valid.
module rational_add_multiply_reduce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rarm_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rarm_pkg::t_out_beat  o_out_data
);

    localparam int OB = rarm_pkg::OPERAND_BITS;
    localparam int W  = rarm_pkg::RAW_BITS;
    localparam int AW = rarm_pkg::ALU_BITS;
    localparam int KW = $clog2(W + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]          r_state, n_state;
    rarm_pkg::t_in_beat  r_in, n_in;
    logic [2*OB-1:0]     r_prod, n_prod;
    logic [W-1:0]        r_num, n_num;
    logic [W-1:0]        r_den, n_den;
    logic [W-1:0]        r_x, n_x;
    logic [W-1:0]        r_y, n_y;
    logic [W-1:0]        r_g, n_g;
    logic [W-1:0]        r_q, n_q;
    logic [W-1:0]        r_rem, n_rem;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_cnt, n_cnt;
    logic                r_eq, n_eq;
    logic                r_ovalid, n_ovalid;
    rarm_pkg::t_out_beat r_out, n_out;

    logic [OB-1:0]       w_ma, w_mb;
    logic [AW-1:0]       w_alu_a, w_alu_b, w_diff;
    logic                w_ge;
    logic [AW-1:0]       w_rem2;
    logic [63:0]         w_num64, w_den64;
    logic                w_accept;

    rarm_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_rem2     = {r_rem, r_q[W-1]};

    // multiplier operand select per sequencer step
    always_comb begin
        w_ma = r_in.a_denominator;
        w_mb = r_in.b_denominator;
        case (r_state)
            S_M1: begin
                w_ma = r_in.a_numerator;
                w_mb = (r_in.cmd == rarm_pkg::CMD_ADD) ? r_in.b_denominator
                                                       : r_in.b_numerator;
            end
            S_M2: begin
                w_ma = r_in.b_numerator;
                w_mb = r_in.a_denominator;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_state == S_GCD) begin
            w_alu_a = {1'b0, r_x};
            w_alu_b = {1'b0, r_y};
        end else begin
            w_alu_a = w_rem2;
            w_alu_b = {1'b0, r_g};
        end
    end

    assign w_num64 = 64'(r_num);
    assign w_den64 = 64'(r_den);

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_prod   = w_ma * w_mb;
        n_num    = r_num;
        n_den    = r_den;
        n_x      = r_x;
        n_y      = r_y;
        n_g      = r_g;
        n_q      = r_q;
        n_rem    = r_rem;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_eq     = r_eq;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_in  = i_in_data;
                    n_num = '0;
                    n_den = '0;
                    n_eq  = 1'b0;
                    if (i_in_data.cmd == rarm_pkg::CMD_ADD ||
                        i_in_data.cmd == rarm_pkg::CMD_MUL) begin
                        n_state = S_M0;
                    end else begin
                        n_eq    = (i_in_data.cmd == rarm_pkg::CMD_EQ) &&
                                  (i_in_data.a_numerator == i_in_data.b_numerator) &&
                                  (i_in_data.a_denominator == i_in_data.b_denominator);
                        n_state = S_DONE;
                    end
                end
            end
            S_M0: n_state = S_M1;
            S_M1: begin
                n_den   = W'(r_prod);
                n_state = S_M2;
            end
            S_M2: begin
                n_num   = W'(r_prod);
                n_state = S_M3;
            end
            S_M3: begin
                if (r_in.cmd == rarm_pkg::CMD_ADD) begin
                    n_num = r_num + W'(r_prod);
                end
                // zero raw part: no reduction
                if (n_num == '0 || r_den == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_x     = n_num;
                    n_y     = r_den;
                    n_k     = '0;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_x == '0 || r_y == '0) begin
                    n_g     = (r_x == '0) ? (r_y << r_k) : (r_x << r_k);
                    n_q     = r_num;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (w_ge) begin
                    n_x = w_diff[W-1:0];
                end else begin
                    // put the larger one in x for the next subtract
                    n_x = r_y;
                    n_y = r_x;
                end
            end
            S_DIVN, S_DIVD: begin
                n_rem = w_ge ? w_diff[W-1:0] : w_rem2[W-1:0];
                n_q   = {r_q[W-2:0], w_ge};
                n_cnt = r_cnt + KW'(1);
                if (r_cnt == KW'(W - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (r_state == S_DIVN) begin
                        n_num   = {r_q[W-2:0], w_ge};
                        n_q     = r_den;
                        n_state = S_DIVD;
                    end else begin
                        n_den   = {r_q[W-2:0], w_ge};
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.result_numerator   = w_num64[rarm_pkg::NUM_OUT_BITS-1:0];
                    n_out.result_denominator = w_den64[rarm_pkg::DEN_OUT_BITS-1:0];
                    n_out.fractions_equal    = r_eq;
                    n_ovalid                 = 1'b1;
                    n_state                  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_prod <= n_prod;
        r_num  <= n_num;
        r_den  <= n_den;
        r_x    <= n_x;
        r_y    <= n_y;
        r_g    <= n_g;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_eq   <= n_eq;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle after accepting a beat");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN || r_state == S_DIVD) |-> (r_g != '0))
        else $error("division by zero gcd");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> (r_ovalid && $stable(r_out)))
        else $error("stalled result changed");

    a_eq_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.fractions_equal) |->
        (r_out.result_numerator == '0 && r_out.result_denominator == '0))
        else $error("compare result carries fraction fields");

endmodule
